FILE: rtl/core/dirent_pkg.sv
`default_nettype none
// ============================================================================
// dirent_pkg
// Shared types, constants and letter tables for the directory listing filter.
// ============================================================================
package dirent_pkg;

    localparam int NAME_CHARS = 16;
    localparam int LINE_BYTES = 32;
    localparam int CORE_BYTES = 24;
    localparam int LEN_W      = 5;
    localparam int CNT_W      = 5;
    localparam int CFG_W      = 64;
    localparam int CFG_IDX_W  = 2;

    localparam logic [7:0] PAD_CHAR   = 8'hA0;
    localparam logic [7:0] QMARK      = 8'h3F;
    localparam logic [7:0] STAR       = 8'h2A;
    localparam logic [7:0] SPACE      = 8'h20;
    localparam logic [7:0] QUOTE      = 8'h22;
    localparam logic [7:0] LT_CHAR    = 8'h3C;
    localparam logic [7:0] LINK_BYTE  = 8'h01;
    localparam logic [7:0] ZERO_BYTE  = 8'h00;
    localparam logic [7:0] CLOSED_BIT = 8'h80;
    localparam logic [7:0] PROT_BIT   = 8'h40;

    localparam logic [CFG_IDX_W-1:0] CFG_PAT_LO  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAT_HI  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PAT_LEN = 2'd2;

    typedef logic [LINE_BYTES-1:0][7:0] t_line;

    typedef struct packed {
        logic ok;
        logic star;
        logic pad;
    } t_lane_flags;

    typedef struct packed {
        logic [7:0]                        entry_type;
        logic [15:0]                       block_count;
        logic [NAME_CHARS-1:0][7:0]        name;
        logic [NAME_CHARS-1:0]             ok;
        logic [NAME_CHARS-1:0]             star;
        logic [NAME_CHARS-1:0]             pad;
    } t_ent_s1;

    function automatic logic [7:0] letter_a(input logic [3:0] t);
        logic [7:0] c;
        case (t)
            4'd0:    c = 8'h44;
            4'd1:    c = 8'h53;
            4'd2:    c = 8'h50;
            4'd3:    c = 8'h55;
            4'd4:    c = 8'h52;
            4'd5:    c = 8'h45;
            4'd6:    c = 8'h45;
            4'd7:    c = 8'h52;
            4'd8:    c = 8'h53;
            4'd9:    c = 8'h45;
            4'd10:   c = 8'h4C;
            4'd11:   c = 8'h51;
            4'd12:   c = 8'h47;
            4'd13:   c = 8'h52;
            4'd14:   c = 8'h4C;
            default: c = QMARK;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] letter_b(input logic [3:0] t);
        logic [7:0] c;
        case (t)
            4'd0:    c = 8'h45;
            4'd1:    c = 8'h45;
            4'd2:    c = 8'h52;
            4'd3:    c = 8'h53;
            4'd4:    c = 8'h45;
            4'd5:    c = 8'h4C;
            4'd6:    c = 8'h51;
            4'd7:    c = 8'h47;
            4'd8:    c = 8'h52;
            4'd9:    c = 8'h4C;
            default: c = QMARK;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] letter_c(input logic [3:0] t);
        logic [7:0] c;
        case (t)
            4'd0:    c = 8'h4C;
            4'd1:    c = 8'h51;
            4'd2:    c = 8'h47;
            4'd3:    c = 8'h52;
            4'd4:    c = 8'h4C;
            default: c = QMARK;
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/core/dirent_in_if.sv
`default_nettype none
// ============================================================================
// dirent_in_if
// Entry channel: one directory entry per beat.
// ============================================================================
interface dirent_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  entry_type;
    logic [15:0] block_count;
    logic [63:0] name_first_half;
    logic [63:0] name_second_half;

    modport source (
        output valid, entry_type, block_count, name_first_half, name_second_half,
        input  ready
    );
    modport sink (
        input  valid, entry_type, block_count, name_first_half, name_second_half,
        output ready
    );
endinterface
`default_nettype wire

FILE: rtl/core/dirent_out_if.sv
`default_nettype none
// ============================================================================
// dirent_out_if
// Line channel: one byte of a listing line per beat.
// ============================================================================
interface dirent_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] line_byte;
    logic       last_of_line;

    modport source (output valid, line_byte, last_of_line, input ready);
    modport sink   (input valid, line_byte, last_of_line, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/dirent_lane.sv
`default_nettype none
// ============================================================================
// dirent_lane
// One character lane: compares a pattern character with a name character.
// ============================================================================
module dirent_lane (
    input  logic [7:0]                i_pat_char,
    input  logic [7:0]                i_name_char,
    output dirent_pkg::t_lane_flags   o_flags
);

    assign o_flags.ok   = (i_pat_char == i_name_char) || (i_pat_char == dirent_pkg::QMARK);
    assign o_flags.star = (i_pat_char == dirent_pkg::STAR);
    assign o_flags.pad  = (i_name_char == dirent_pkg::PAD_CHAR);

endmodule
`default_nettype wire

FILE: rtl/core/dirent_merge.sv
`default_nettype none
// ============================================================================
// dirent_merge
// Combines lane flags into the match decision and builds the listing line.
// ============================================================================
module dirent_merge (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_take,
    input  dirent_pkg::t_ent_s1                   i_ent,
    input  logic [dirent_pkg::LEN_W-1:0]          i_pat_len,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output dirent_pkg::t_line                     o_line
);

    localparam int MID_BYTES = dirent_pkg::CORE_BYTES + 4;

    logic [dirent_pkg::LEN_W-1:0]                  len_c;
    logic                                          found;
    logic                                          star_hit;
    logic                                          match;
    logic                                          pass;
    logic                                          s2_free;
    logic [dirent_pkg::NAME_CHARS-1:0]             seen;
    logic [dirent_pkg::CORE_BYTES-1:0][7:0]        core;
    logic [MID_BYTES-1:0][7:0]                     mid;
    logic                                          lt10;
    logic                                          lt100;
    logic [1:0]                                    lead;
    dirent_pkg::t_line                             n_line;
    logic                                          r_valid;
    dirent_pkg::t_line                             r_line;

    always_comb begin
        len_c = (i_pat_len > dirent_pkg::LEN_W'(dirent_pkg::NAME_CHARS))
              ? dirent_pkg::LEN_W'(dirent_pkg::NAME_CHARS) : i_pat_len;
        found    = 1'b0;
        star_hit = 1'b0;
        for (int i = dirent_pkg::NAME_CHARS - 1; i >= 0; i--) begin
            if ((dirent_pkg::LEN_W'(i) < len_c) && (i_ent.star[i] || !i_ent.ok[i])) begin
                found    = 1'b1;
                star_hit = i_ent.star[i];
            end
        end
        if (len_c == '0) begin
            match = 1'b1;
        end else if (found) begin
            match = star_hit;
        end else if (len_c == dirent_pkg::LEN_W'(dirent_pkg::NAME_CHARS)) begin
            match = 1'b1;
        end else begin
            match = i_ent.pad[len_c[3:0]];
        end
        pass = (i_ent.entry_type != 8'h00) && match;
    end

    always_comb begin
        seen[0] = 1'b0;
        for (int i = 1; i < dirent_pkg::NAME_CHARS; i++) begin
            seen[i] = seen[i-1] | i_ent.pad[i-1];
        end
        core[0] = dirent_pkg::QUOTE;
        for (int i = 0; i < dirent_pkg::NAME_CHARS; i++) begin
            if (i_ent.pad[i]) begin
                core[i+1] = seen[i] ? dirent_pkg::SPACE : dirent_pkg::QUOTE;
            end else begin
                core[i+1] = i_ent.name[i];
            end
        end
        core[17] = (|i_ent.pad) ? dirent_pkg::SPACE : dirent_pkg::QUOTE;
        core[18] = ((i_ent.entry_type & dirent_pkg::CLOSED_BIT) != 8'h00)
                 ? dirent_pkg::SPACE : dirent_pkg::STAR;
        core[19] = dirent_pkg::letter_a(i_ent.entry_type[3:0]);
        core[20] = dirent_pkg::letter_b(i_ent.entry_type[3:0]);
        core[21] = dirent_pkg::letter_c(i_ent.entry_type[3:0]);
        core[22] = ((i_ent.entry_type & dirent_pkg::PROT_BIT) != 8'h00)
                 ? dirent_pkg::LT_CHAR : dirent_pkg::SPACE;
        core[23] = dirent_pkg::SPACE;

        mid[0] = dirent_pkg::SPACE;
        mid[1] = dirent_pkg::SPACE;
        for (int i = 0; i < dirent_pkg::CORE_BYTES; i++) begin
            mid[i+2] = core[i];
        end
        mid[MID_BYTES-2] = dirent_pkg::SPACE;
        mid[MID_BYTES-1] = dirent_pkg::SPACE;

        lt10  = (i_ent.block_count < 16'd10);
        lt100 = (i_ent.block_count < 16'd100);
        lead  = {1'b0, lt10} + {1'b0, lt100};

        n_line    = '0;
        n_line[0] = dirent_pkg::LINK_BYTE;
        n_line[1] = dirent_pkg::LINK_BYTE;
        n_line[2] = i_ent.block_count[7:0];
        n_line[3] = i_ent.block_count[15:8];
        n_line[4] = dirent_pkg::SPACE;
        for (int j = 0; j < MID_BYTES - 2; j++) begin
            case (lead)
                2'd2:    n_line[5+j] = mid[j];
                2'd1:    n_line[5+j] = mid[j+1];
                default: n_line[5+j] = mid[j+2];
            endcase
        end
        n_line[dirent_pkg::LINE_BYTES-1] = dirent_pkg::ZERO_BYTE;
    end

    assign s2_free = !r_valid || i_ready;
    assign o_take  = i_valid && (!pass || s2_free);
    assign o_valid = r_valid;
    assign o_line  = r_line;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (s2_free) begin
            r_valid <= i_valid && pass;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_free && i_valid && pass) begin
            r_line <= n_line;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/dirent_ser.sv
`default_nettype none
// ============================================================================
// dirent_ser
// Line serializer: shifts a 32-byte line out one byte per beat.
// ============================================================================
module dirent_ser (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  dirent_pkg::t_line    i_line,
    dirent_out_if.source         o_line
);

    localparam logic [dirent_pkg::CNT_W-1:0] LAST_CNT =
        dirent_pkg::CNT_W'(dirent_pkg::LINE_BYTES - 1);

    logic                              r_busy;
    logic [dirent_pkg::CNT_W-1:0]      r_cnt;
    dirent_pkg::t_line                 r_buf;
    logic                              beat;
    logic                              last;

    assign last    = (r_cnt == LAST_CNT);
    assign beat    = r_busy && o_line.ready;
    assign o_ready = !r_busy || (beat && last);

    assign o_line.valid        = r_busy;
    assign o_line.line_byte    = r_buf[0];
    assign o_line.last_of_line = last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (o_ready) begin
            r_busy <= i_valid;
            r_cnt  <= '0;
        end else if (beat) begin
            r_cnt <= r_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_buf <= i_line;
        end else if (beat) begin
            r_buf <= {dirent_pkg::ZERO_BYTE, r_buf[dirent_pkg::LINE_BYTES-1:1]};
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/directory_entry_filter_formatter.sv
`default_nettype none
// ============================================================================
// directory_entry_filter_formatter
// Filters directory entries against a wildcard pattern and emits a 32-byte
// listing line for each entry that passes.
//
//   channel   dir   beat carries                                  rate
//   i_ent     in    entry_type, block_count, name halves          1 / cycle when ready
//   o_line    out   line_byte, last_of_line                       1 / cycle when ready
//   i_cfg_*   in    pattern halves, pattern length (write only)   1 / cycle
//
// Sixteen character lanes compare the entry in the cycle it is accepted; the
// merge stage decides the match from the registered flags and builds the line.
// A passing entry occupies the serializer for 32 output beats, so matching
// entries flow at most one per 32 output beats; skipped ones drain one per cycle.
// Stage-1, merge and serializer registers lie between entry and first byte.
// Reset is synchronous and clears all valid flags and the pattern registers.
// ============================================================================
module directory_entry_filter_formatter (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    dirent_in_if.sink                             i_ent,
    dirent_out_if.source                          o_line,
    input  logic                                  i_cfg_we,
    input  logic [dirent_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [dirent_pkg::CFG_W-1:0]          i_cfg_data
);

    logic [dirent_pkg::CFG_W-1:0]                 r_pat_lo;
    logic [dirent_pkg::CFG_W-1:0]                 r_pat_hi;
    logic [dirent_pkg::LEN_W-1:0]                 r_pat_len;

    logic [dirent_pkg::NAME_CHARS-1:0][7:0]       pat;
    logic [dirent_pkg::NAME_CHARS-1:0][7:0]       name;
    dirent_pkg::t_lane_flags                      lane_flags [dirent_pkg::NAME_CHARS];
    dirent_pkg::t_ent_s1                          n_s1;
    dirent_pkg::t_ent_s1                          r_s1;
    logic                                         r_s1_valid;
    logic                                         s1_take;
    logic                                         in_beat;
    logic                                         line_valid;
    logic                                         line_ready;
    dirent_pkg::t_line                            line;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_lo  <= '0;
            r_pat_hi  <= '0;
            r_pat_len <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                dirent_pkg::CFG_PAT_LO:  r_pat_lo  <= i_cfg_data;
                dirent_pkg::CFG_PAT_HI:  r_pat_hi  <= i_cfg_data;
                dirent_pkg::CFG_PAT_LEN: r_pat_len <= i_cfg_data[dirent_pkg::LEN_W-1:0];
                default: ;
            endcase
        end
    end

    assign pat  = {r_pat_hi, r_pat_lo};
    assign name = {i_ent.name_second_half, i_ent.name_first_half};

    for (genvar g = 0; g < dirent_pkg::NAME_CHARS; g++) begin : g_lane
        dirent_lane u_lane (
            .i_pat_char  (pat[g]),
            .i_name_char (name[g]),
            .o_flags     (lane_flags[g])
        );
    end

    always_comb begin
        n_s1.entry_type  = i_ent.entry_type;
        n_s1.block_count = i_ent.block_count;
        n_s1.name        = name;
        for (int i = 0; i < dirent_pkg::NAME_CHARS; i++) begin
            n_s1.ok[i]   = lane_flags[i].ok;
            n_s1.star[i] = lane_flags[i].star;
            n_s1.pad[i]  = lane_flags[i].pad;
        end
    end

    assign i_ent.ready = !r_s1_valid || s1_take;
    assign in_beat     = i_ent.valid && i_ent.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_ent.ready) begin
            r_s1_valid <= i_ent.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_s1 <= n_s1;
        end
    end

    dirent_merge u_merge (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (r_s1_valid),
        .o_take    (s1_take),
        .i_ent     (r_s1),
        .i_pat_len (r_pat_len),
        .o_valid   (line_valid),
        .i_ready   (line_ready),
        .o_line    (line)
    );

    dirent_ser u_ser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (line_valid),
        .o_ready (line_ready),
        .i_line  (line),
        .o_line  (o_line)
    );

endmodule
`default_nettype wire
